### hw/rtl/sprc_pkg.sv
// Shared types, widths and constants for the sparse product row-count block.
package sprc_pkg;

	// Default matrix dimensions.
	localparam int B_ROWS_DEF   = 1024;
	localparam int B_NNZ_DEF    = 8192;
	localparam int OUT_COLS_DEF = 1024;

	// Fixed field widths of the stream items.
	localparam int CMD_W     = 2;
	localparam int ADDR_W    = 13;
	localparam int VAL_W     = 14;
	localparam int COL_W     = 11;
	localparam int LEN_W     = 11;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 16;

	// Bit positions of the input fields inside tdata.
	localparam int CMD_LSB  = 0;
	localparam int ADDR_LSB = CMD_LSB + CMD_W;
	localparam int VAL_LSB  = ADDR_LSB + ADDR_W;

	// Width of the row tag kept per output column in the seen map.
	localparam int EPOCH_W = 8;

	// Upper bound used when only the lower bound of a pointer is checked.
	localparam logic [31:0] PTR_SPAN = 32'd1 << VAL_W;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_INDEX_BASE = 1'b0;

	// Command codes carried in the cmd field.
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD_PTR = 2'd0,
		CMD_LOAD_COL = 2'd1,
		CMD_A_ENTRY  = 2'd2,
		CMD_A_EMPTY  = 2'd3
	} cmd_t;

	// Request to the shared rebase and range-check unit.
	typedef struct packed {
		logic [VAL_W-1:0] raw;
		logic             base;
		logic [31:0]      limit;
	} rebase_req_t;

	// Answer of the shared rebase and range-check unit.
	typedef struct packed {
		logic             ok;
		logic [VAL_W-1:0] idx;
	} rebase_res_t;

endpackage

### hw/rtl/sprc_rebase.sv
// Shared unit that removes the index base from a value and checks its range.
module sprc_rebase
	import sprc_pkg::*;
(
	input  rebase_req_t req,
	output rebase_res_t res
);

	logic [VAL_W-1:0] base_ext;
	logic [VAL_W-1:0] diff;
	logic [31:0]      diff_ext;

	// Subtract the base, then the value is valid if it did not go below zero
	// and stays under the limit.
	always_comb begin
		base_ext = {{(VAL_W-1){1'b0}}, req.base};
		diff     = req.raw - base_ext;
		diff_ext = {{(32-VAL_W){1'b0}}, diff};
		res.ok   = (req.raw >= base_ext) && (diff_ext < req.limit);
		res.idx  = diff;
	end

endmodule

### hw/rtl/spgemm_symbolic_row_count.sv
// Top level of the symbolic row-count block for a row-by-row sparse product.
//
// Matrix B is loaded first through the input stream: row pointers with cmd 0 and
// column indices with cmd 1, each written as it is taken. Then every column
// index of an A row arrives as one cmd 2 item; the block reads the two row
// pointers of the matching B row and walks that row, one B nonzero per pass
// through the walk, column and seen steps, through a single memory port per
// table and one shared rebase and range-check unit. When the row closes, its
// result is handed over. The stream is not ready while an entry is walked. The
// seen map holds a row tag per output column instead of a bit, so closing a row
// costs no clearing; after reset, and again after every 255 closed rows when the
// tag wraps, a clearing pass over every seen map entry runs during which no item
// is taken (configuration writes are still accepted).
module spgemm_symbolic_row_count
	import sprc_pkg::*;
#(
	parameter int B_ROWS   = B_ROWS_DEF,
	parameter int B_NNZ    = B_NNZ_DEF,
	parameter int OUT_COLS = OUT_COLS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Input stream.
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // cmd[1:0], address[14:2], value[28:15], zeros
	input  logic                  s_tlast,
	// Result stream.
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // row_len[10:0], zeros
	output logic                  m_tuser,  // bad_index[0]
	// Configuration port.
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [PDATA_W-1:0]    pwdata,
	output logic [PDATA_W-1:0]    prdata,
	output logic                  pready
);

	localparam int RS_DEPTH = B_ROWS + 1;
	localparam int RS_AW    = $clog2(RS_DEPTH);
	localparam int CB_AW    = (B_NNZ > 1) ? $clog2(B_NNZ) : 1;
	localparam int SEEN_AW  = (OUT_COLS > 1) ? $clog2(OUT_COLS) : 1;
	localparam logic [EPOCH_W-1:0] EPOCH_LAST = {EPOCH_W{1'b1}};
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = {{(EPOCH_W-1){1'b0}}, 1'b1};
	localparam logic [SEEN_AW-1:0] CLR_LAST = SEEN_AW'(OUT_COLS - 1);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RS0,
		ST_RS1,
		ST_RS2,
		ST_WALK,
		ST_COL,
		ST_SEEN,
		ST_FINISH,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Configuration register.
	logic index_base_q;

	// Sequencer registers.
	logic [RS_AW-1:0]   row_q;
	logic [VAL_W-1:0]   j_q;
	logic [VAL_W-1:0]   end_q;
	logic               p0_ok_q;
	logic               last_q;
	logic [SEEN_AW-1:0] cb_q;
	logic [LEN_W-1:0]   count_q;
	logic               row_err_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [SEEN_AW-1:0] clr_q;

	// Result register.
	logic               out_valid_q;
	logic [LEN_W-1:0]   out_len_q;
	logic               out_bad_q;

	// Memories and their registered read data.
	logic [VAL_W-1:0]   rs_mem [RS_DEPTH];
	logic [COL_W-1:0]   col_mem [B_NNZ];
	logic [EPOCH_W-1:0] seen_mem [OUT_COLS];
	logic [VAL_W-1:0]   rs_rdata_q;
	logic [COL_W-1:0]   col_rdata_q;
	logic [EPOCH_W-1:0] seen_rdata_q;

	// Input fields.
	logic [CMD_W-1:0]  in_cmd;
	logic [ADDR_W-1:0] in_addr;
	logic [VAL_W-1:0]  in_val;
	logic [31:0]       addr_ext;
	logic              in_fire;
	logic              out_free;

	// Shared unit.
	rebase_req_t unit_req;
	rebase_res_t unit_res;
	logic [31:0] unit_idx_ext;
	logic [31:0] j_ext;

	// Memory ports.
	logic [RS_AW-1:0]   rs_raddr;
	logic               rs_we;
	logic               col_we;
	logic [SEEN_AW-1:0] seen_raddr;
	logic               seen_we;
	logic [SEEN_AW-1:0] seen_waddr;
	logic [EPOCH_W-1:0] seen_wdata;
	logic               cfg_we;

	assign in_cmd   = s_tdata[CMD_LSB +: CMD_W];
	assign in_addr  = s_tdata[ADDR_LSB +: ADDR_W];
	assign in_val   = s_tdata[VAL_LSB +: VAL_W];
	assign addr_ext = {{(32-ADDR_W){1'b0}}, in_addr};
	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign j_ext    = {{(32-VAL_W){1'b0}}, j_q};

	// Result stream outputs.
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W-LEN_W){1'b0}}, out_len_q};
	assign m_tuser  = out_bad_q;

	// Configuration port: one register at byte address zero.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[2:2] == REG_INDEX_BASE) ? {{(PDATA_W-1){1'b0}}, index_base_q}
	                                                : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_base_q <= 1'b0;
		end else if (cfg_we && paddr[2:2] == REG_INDEX_BASE) begin
			index_base_q <= pwdata[0];
		end
	end

	// Operand selection for the shared rebase unit, by sequencer step.
	always_comb begin
		unit_req.base = index_base_q;
		case (state_q)
			ST_RS1, ST_RS2: begin
				unit_req.raw   = rs_rdata_q;
				unit_req.limit = PTR_SPAN;
			end
			ST_COL: begin
				unit_req.raw   = {{(VAL_W-COL_W){1'b0}}, col_rdata_q};
				unit_req.limit = 32'(OUT_COLS);
			end
			default: begin
				unit_req.raw   = in_val;
				unit_req.limit = 32'(B_ROWS);
			end
		endcase
	end

	sprc_rebase u_rebase (
		.req (unit_req),
		.res (unit_res)
	);

	assign unit_idx_ext = {{(32-VAL_W){1'b0}}, unit_res.idx};

	// Memory addresses and write enables.
	always_comb begin
		rs_raddr   = (state_q == ST_RS1) ? RS_AW'(row_q + 1'b1) : row_q;
		rs_we      = in_fire && (in_cmd == CMD_LOAD_PTR) && (addr_ext <= 32'(B_ROWS));
		col_we     = in_fire && (in_cmd == CMD_LOAD_COL) && (addr_ext < 32'(B_NNZ));
		seen_raddr = unit_idx_ext[SEEN_AW-1:0];
		seen_we    = 1'b0;
		seen_waddr = cb_q;
		seen_wdata = epoch_q;
		if (state_q == ST_CLEAR) begin
			seen_we    = 1'b1;
			seen_waddr = clr_q;
			seen_wdata = '0;
		end else if (state_q == ST_SEEN && seen_rdata_q != epoch_q) begin
			seen_we = 1'b1;
		end
	end

	// Row pointer memory.
	always_ff @(posedge clk) begin
		if (rs_we) begin
			rs_mem[addr_ext[RS_AW-1:0]] <= in_val;
		end
		rs_rdata_q <= rs_mem[rs_raddr];
	end

	// Column index memory.
	always_ff @(posedge clk) begin
		if (col_we) begin
			col_mem[addr_ext[CB_AW-1:0]] <= in_val[COL_W-1:0];
		end
		col_rdata_q <= col_mem[j_ext[CB_AW-1:0]];
	end

	// Seen map: each entry holds the tag of the last row that marked it.
	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[seen_waddr] <= seen_wdata;
		end
		seen_rdata_q <= seen_mem[seen_raddr];
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			epoch_q     <= EPOCH_FIRST;
			count_q     <= '0;
			row_err_q   <= 1'b0;
			last_q      <= 1'b0;
			p0_ok_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// The emit step either refills or holds the result register itself.
			if (out_valid_q && m_tready && state_q != ST_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				// Wipe the seen map, one entry per cycle.
				ST_CLEAR: begin
					if (clr_q == CLR_LAST) begin
						clr_q   <= '0;
						epoch_q <= EPOCH_FIRST;
						state_q <= ST_IDLE;
					end else begin
						clr_q <= SEEN_AW'(clr_q + 1'b1);
					end
				end
				// Take an item; loads finish in this cycle.
				ST_IDLE: begin
					if (in_fire) begin
						case (in_cmd)
							CMD_A_ENTRY: begin
								last_q <= s_tlast;
								if (unit_res.ok) begin
									row_q   <= unit_idx_ext[RS_AW-1:0];
									state_q <= ST_RS0;
								end else begin
									row_err_q <= 1'b1;
									state_q   <= ST_FINISH;
								end
							end
							CMD_A_EMPTY: begin
								state_q <= ST_EMIT;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				// Start pointer read is in flight.
				ST_RS0: begin
					state_q <= ST_RS1;
				end
				// Start pointer is here; end pointer read is in flight.
				ST_RS1: begin
					p0_ok_q <= unit_res.ok;
					j_q     <= unit_res.idx;
					state_q <= ST_RS2;
				end
				// End pointer is here.
				ST_RS2: begin
					if (!p0_ok_q || !unit_res.ok) begin
						row_err_q <= 1'b1;
						state_q   <= ST_FINISH;
					end else begin
						end_q   <= unit_res.idx;
						state_q <= ST_WALK;
					end
				end
				// Next position of the B row, or the end of the walk.
				ST_WALK: begin
					if (j_q >= end_q) begin
						state_q <= ST_FINISH;
					end else if (j_ext >= 32'(B_NNZ)) begin
						row_err_q <= 1'b1;
						state_q   <= ST_FINISH;
					end else begin
						state_q <= ST_COL;
					end
				end
				// Column index is here; check it and look up its seen tag.
				ST_COL: begin
					if (unit_res.ok) begin
						cb_q    <= unit_idx_ext[SEEN_AW-1:0];
						state_q <= ST_SEEN;
					end else begin
						row_err_q <= 1'b1;
						j_q       <= j_q + 1'b1;
						state_q   <= ST_WALK;
					end
				end
				// Count the column if this row has not marked it yet.
				ST_SEEN: begin
					if (seen_rdata_q != epoch_q) begin
						count_q <= count_q + 1'b1;
					end
					j_q     <= j_q + 1'b1;
					state_q <= ST_WALK;
				end
				// Entry done: close the row if it was the last one.
				ST_FINISH: begin
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				// Hand the row result over once the result register is free.
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_len_q   <= count_q;
						out_bad_q   <= row_err_q;
						count_q     <= '0;
						row_err_q   <= 1'b0;
						if (epoch_q == EPOCH_LAST) begin
							state_q <= ST_CLEAR;
						end else begin
							epoch_q <= epoch_q + 1'b1;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
